// File: sv/h264_keyframe_detector_core_defines.svh
// Assertion macros shared by the keyframe detector RTL.
// Both expect aclk and aresetn in scope.
`ifndef H264_KEYFRAME_DETECTOR_CORE_DEFINES_SVH
`define H264_KEYFRAME_DETECTOR_CORE_DEFINES_SVH

// Same-cycle implication
`define H264KD_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define H264KD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/h264kd_pkg.sv
`timescale 1ns / 1ps

package h264kd_pkg;

    // Walker count: index 0 uses 4-byte lengths, index 1 uses 2-byte lengths
    localparam int NUM_WALKS = 2;
    localparam int WALK_LONG = 0;
    localparam int WALK_SHORT = 1;

    // Width of the per-walk unit byte counter; longer lengths fail the walk
    localparam int LEN_CNT_W = 32;

    localparam logic [4:0]  NAL_TYPE_MASK = 5'h1F;
    localparam logic [4:0]  NAL_TYPE_IDR  = 5'd5;
    localparam logic [23:0] START_CODE    = 24'h000001;
    localparam logic [23:0] RECENT_RESET  = 24'hFFFFFF;

    typedef enum logic [1:0] {
        PH_LEN   = 2'd0,
        PH_UNIT  = 2'd1,
        PH_FAIL  = 2'd2,
        PH_FOUND = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        ST_INVALID = 2'd0,
        ST_VALID   = 2'd1,
        ST_FOUND   = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        FB_NONE  = 2'd0,
        FB_START = 2'd1,
        FB_LONG  = 2'd2,
        FB_SHORT = 2'd3
    } found_t;

    typedef struct packed {
        status_t long_st;
        status_t short_st;
    } walk_status_t;

    // Length prefix size in bytes for each walker
    function automatic int prefix_bytes(input int w);
        return (w == WALK_LONG) ? 4 : 2;
    endfunction

endpackage

// File: sv/h264kd_walks.sv
`timescale 1ns / 1ps

module h264kd_walks
    import h264kd_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         beat_en,
    input  logic [7:0]   data_byte,
    input  logic         last_byte,
    output walk_status_t status     // status after this beat, before the frame clear
);

    status_t st [NUM_WALKS];

    for (genvar w = 0; w < NUM_WALKS; w++) begin : g_walk
        localparam int PB = prefix_bytes(w);
        localparam int AW = PB * 8;
        localparam int SW = $clog2(PB + 1);

        phase_t                phase_reg, phase_next;
        logic [AW-1:0]         acc_reg, acc_next;
        logic [SW-1:0]         seen_reg, seen_next;
        logic [LEN_CNT_W-1:0]  left_reg, left_next;
        logic                  first_reg, first_next;
        logic                  idr_reg, idr_next;

        logic [AW-1:0]         acc_shift;
        logic [63:0]           len_wide;
        logic                  too_long;
        logic                  idr_hit;

        assign acc_shift = {acc_reg[AW-9:0], data_byte};
        assign len_wide  = 64'(acc_shift);
        assign too_long  = (len_wide >> LEN_CNT_W) != 64'd0;
        assign idr_hit   = idr_reg
                         | (first_reg && ((data_byte[4:0] & NAL_TYPE_MASK) == NAL_TYPE_IDR));

        // Next state of the walk for this byte
        always_comb begin
            phase_next = phase_reg;
            acc_next   = acc_reg;
            seen_next  = seen_reg;
            left_next  = left_reg;
            first_next = first_reg;
            idr_next   = idr_reg;
            unique case (phase_reg)
                PH_LEN: begin
                    acc_next  = acc_shift;
                    seen_next = SW'(seen_reg + 1'b1);
                    if (seen_reg == SW'(PB - 1)) begin
                        if (acc_shift == '0 || too_long) begin
                            phase_next = PH_FAIL;
                        end else begin
                            left_next  = len_wide[LEN_CNT_W-1:0];
                            idr_next   = 1'b0;
                            first_next = 1'b1;
                            phase_next = PH_UNIT;
                        end
                    end
                end
                PH_UNIT: begin
                    idr_next   = idr_hit;
                    first_next = 1'b0;
                    left_next  = left_reg - 1'b1;
                    if (left_reg == LEN_CNT_W'(1)) begin
                        if (idr_hit) begin
                            phase_next = PH_FOUND;
                        end else begin
                            phase_next = PH_LEN;
                            acc_next   = '0;
                            seen_next  = '0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        // Status as seen at the end of this byte
        always_comb begin
            unique case (phase_next)
                PH_FOUND: st[w] = ST_FOUND;
                PH_LEN:   st[w] = (seen_next == '0) ? ST_VALID : ST_INVALID;
                default:  st[w] = ST_INVALID;
            endcase
        end

        // Walk registers, cleared at the end of every frame
        always_ff @(posedge aclk) begin
            if (!aresetn || (beat_en && last_byte)) begin
                phase_reg <= PH_LEN;
                acc_reg   <= '0;
                seen_reg  <= '0;
                left_reg  <= '0;
                first_reg <= 1'b0;
                idr_reg   <= 1'b0;
            end else if (beat_en) begin
                phase_reg <= phase_next;
                acc_reg   <= acc_next;
                seen_reg  <= seen_next;
                left_reg  <= left_next;
                first_reg <= first_next;
                idr_reg   <= idr_next;
            end
        end
    end

    assign status.long_st  = st[WALK_LONG];
    assign status.short_st = st[WALK_SHORT];

endmodule

// File: sv/h264_keyframe_detector_core.sv
// The verdict is registered into m_tdata when the frame's tlast beat is taken.
// Throughput: one byte per cycle; s_tready drops only while a verdict waits on m_tready.
// Every byte updates the start-code window and both length walkers.
// Reset (aresetn low, synchronous) clears all frame state and the output valid flag.
`timescale 1ns / 1ps

`include "h264_keyframe_detector_core_defines.svh"

module h264_keyframe_detector_core
    import h264kd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,     // [7:0] data_byte
    input  logic       s_tlast,     // last_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata      // [0] is_keyframe, [2:1] found_by,
                                    // [4:3] long_prefix_status,
                                    // [6:5] short_prefix_status, [7] zero
);

    logic         s_beat;
    logic [23:0]  recent_reg;
    logic         sc_hit_reg;
    logic         sc_hit_now;
    walk_status_t walk_st;
    found_t       found_next;
    logic         m_valid_reg;
    logic [7:0]   m_data_reg;

    assign s_tready = !m_valid_reg || m_tready;
    assign s_beat   = s_tvalid && s_tready;

    h264kd_walks u_walks (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .beat_en   (s_beat),
        .data_byte (s_tdata),
        .last_byte (s_tlast),
        .status    (walk_st)
    );

    // Start code 00 00 01 followed by an IDR header
    assign sc_hit_now = sc_hit_reg
                      || (recent_reg == START_CODE
                          && (s_tdata[4:0] & NAL_TYPE_MASK) == NAL_TYPE_IDR);

    always_ff @(posedge aclk) begin
        if (!aresetn || (s_beat && s_tlast)) begin
            recent_reg <= RECENT_RESET;
            sc_hit_reg <= 1'b0;
        end else if (s_beat) begin
            recent_reg <= {recent_reg[15:0], s_tdata};
            sc_hit_reg <= sc_hit_now;
        end
    end

    // Verdict priority: start code, then 4-byte walk, then 2-byte walk if the 4-byte walk is invalid
    always_comb begin
        if (sc_hit_now) begin
            found_next = FB_START;
        end else if (walk_st.long_st == ST_FOUND) begin
            found_next = FB_LONG;
        end else if (walk_st.long_st == ST_INVALID && walk_st.short_st == ST_FOUND) begin
            found_next = FB_SHORT;
        end else begin
            found_next = FB_NONE;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_beat && s_tlast) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_beat && s_tlast) begin
            m_data_reg <= {1'b0, walk_st.short_st, walk_st.long_st, found_next,
                           found_next != FB_NONE};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    `H264KD_ASSERT_NEXT(a_last_gives_result, s_beat && s_tlast, m_tvalid, "no result after last beat")
    `H264KD_ASSERT_IMPL(a_flag_matches_kind, m_tvalid, m_tdata[0] == (m_tdata[2:1] != FB_NONE), "is_keyframe mismatch")
    `H264KD_ASSERT_IMPL(a_long_kind_found, m_tvalid && m_tdata[2:1] == FB_LONG, m_tdata[4:3] == ST_FOUND, "long verdict without long find")
    `H264KD_ASSERT_IMPL(a_short_kind_rule, m_tvalid && m_tdata[2:1] == FB_SHORT, m_tdata[4:3] == ST_INVALID && m_tdata[6:5] == ST_FOUND, "short verdict rule broken")
    `H264KD_ASSERT_NEXT(a_frame_clears_window, s_beat && s_tlast, recent_reg == RECENT_RESET && !sc_hit_reg, "frame state not cleared")

endmodule
